>>> hdl/afhp_pkg.sv
// ----------------------------------------------------------------------------
// afhp_pkg
// Shared types and constants of the audio frame header parser.
// ----------------------------------------------------------------------------
package afhp_pkg;

  // Header layout
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned MAGIC_AT     = 0;
  localparam int unsigned VERSION_AT   = 4;
  localparam int unsigned FLAGS_AT     = 5;
  localparam int unsigned SEQ_AT       = 8;
  localparam int unsigned STAMP_AT     = 12;
  localparam int unsigned LEN_AT       = 20;

  // Magic bytes, in arrival order
  localparam logic [7:0] MAGIC0 = 8'h53;
  localparam logic [7:0] MAGIC1 = 8'h43;
  localparam logic [7:0] MAGIC2 = 8'h4D;
  localparam logic [7:0] MAGIC3 = 8'h54;

  // Version after reset
  localparam logic [7:0] VERSION_RESET = 8'h01;

  // One parsed header
  typedef struct packed {
    logic               header_ok;
    logic [7:0]         frame_flags;
    logic [31:0]        sequence_number;
    logic signed [63:0] frame_stamp;
    logic [31:0]        payload_bytes;
  } afhp_result_t;

endpackage

>>> hdl/afhp_intf.sv
// ----------------------------------------------------------------------------
// afhp_intf
// Valid/ready channels of the audio frame header parser.
// ----------------------------------------------------------------------------

// Frame byte stream
interface afhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// Parsed header results
interface afhp_hdr_if;
  logic               valid;
  logic               ready;
  logic               header_ok;
  logic [7:0]         frame_flags;
  logic [31:0]        sequence_number;
  logic signed [63:0] frame_stamp;
  logic [31:0]        payload_bytes;

  modport source (output valid, output header_ok, output frame_flags,
                  output sequence_number, output frame_stamp,
                  output payload_bytes, input ready);
  modport sink   (input valid, input header_ok, input frame_flags,
                  input sequence_number, input frame_stamp,
                  input payload_bytes, output ready);
endinterface

// Version register write channel
interface afhp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/afhp_parser.sv
// ----------------------------------------------------------------------------
// afhp_parser
// Per-frame byte counter, magic/version check and header field gathering.
// ----------------------------------------------------------------------------
module afhp_parser
  import afhp_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 33
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,      // consume the byte below this cycle
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  input  logic [7:0]   version_i,
  output afhp_result_t res_o        // result of the byte below, if last
);

  localparam int unsigned CW = ((COUNT_BITS > 33) ? COUNT_BITS : 33) + 1;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  prefix_q, prefix_d;
  logic [7:0]            flags_q, flags_d;
  logic [31:0]           seq_q, seq_d;
  logic [63:0]           ts_q, ts_d;
  logic [31:0]           len_q, len_d;
  logic [CW-1:0]         total;
  logic [CW-1:0]         need;
  logic                  ok;

  // Next state for the current byte
  always_comb begin
    prefix_d = prefix_q;
    flags_d  = flags_q;
    seq_d    = seq_q;
    ts_d     = ts_q;
    len_d    = len_q;

    if (count_q == COUNT_BITS'(MAGIC_AT)     && byte_i != MAGIC0)    prefix_d = 1'b0;
    if (count_q == COUNT_BITS'(MAGIC_AT + 1) && byte_i != MAGIC1)    prefix_d = 1'b0;
    if (count_q == COUNT_BITS'(MAGIC_AT + 2) && byte_i != MAGIC2)    prefix_d = 1'b0;
    if (count_q == COUNT_BITS'(MAGIC_AT + 3) && byte_i != MAGIC3)    prefix_d = 1'b0;
    if (count_q == COUNT_BITS'(VERSION_AT)   && byte_i != version_i) prefix_d = 1'b0;
    if (count_q == COUNT_BITS'(FLAGS_AT)) flags_d = byte_i;

    // big-endian shift-in of the multi-byte fields
    if (count_q >= COUNT_BITS'(SEQ_AT) && count_q < COUNT_BITS'(SEQ_AT + 4)) begin
      seq_d = {seq_q[23:0], byte_i};
    end
    if (count_q >= COUNT_BITS'(STAMP_AT) && count_q < COUNT_BITS'(STAMP_AT + 8)) begin
      ts_d = {ts_q[55:0], byte_i};
    end
    if (count_q >= COUNT_BITS'(LEN_AT) && count_q < COUNT_BITS'(LEN_AT + 4)) begin
      len_d = {len_q[23:0], byte_i};
    end

    // saturating byte count
    count_d = (count_q == '1) ? count_q : count_q + COUNT_BITS'(1);
  end

  // Length checks against the count including this byte
  assign total = CW'(count_d);
  assign need  = CW'(len_d) + CW'(HEADER_BYTES);
  assign ok    = prefix_d && (total >= CW'(HEADER_BYTES)) && (total >= need);

  // Rejected frames report zero fields
  always_comb begin
    res_o.header_ok       = ok;
    res_o.frame_flags     = ok ? flags_d : 8'd0;
    res_o.sequence_number = ok ? seq_d : 32'd0;
    res_o.frame_stamp     = ok ? $signed(ts_d) : 64'sd0;
    res_o.payload_bytes   = ok ? len_d : 32'd0;
  end

  // Frame state; cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      prefix_q <= 1'b1;
    end else if (step_i) begin
      if (last_i) begin
        count_q  <= '0;
        prefix_q <= 1'b1;
      end else begin
        count_q  <= count_d;
        prefix_q <= prefix_d;
      end
    end
  end

  // Gathered fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      seq_q   <= '0;
      ts_q    <= '0;
      len_q   <= '0;
    end else if (step_i) begin
      flags_q <= flags_d;
      seq_q   <= seq_d;
      ts_q    <= ts_d;
      len_q   <= len_d;
    end
  end

endmodule

>>> hdl/audio_frame_header_parser_core.sv
// ----------------------------------------------------------------------------
// audio_frame_header_parser_core
// Checks and unpacks the 24-byte header of byte-serial audio frames.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i carries one frame byte per transfer, frame_end high on the last
//   byte. For every last byte one transfer leaves on hdr_o: header_ok plus
//   flags, sequence, timestamp and payload length (all zero when rejected).
//   cfg_i writes the expected version byte; it is always ready and should
//   be written only while no frame is in flight.
// Throughput: one byte per clock, for any frame length, while no frame end
//   waits on a full result register. Path: a last byte passes the input
//   register, then parser logic into the result register.
// Reset: counter cleared, magic check armed, version back to 1, no result
//   pending.
// Stall: a waiting result holds hdr_o steady; bytes that are not frame ends
//   keep flowing, and only a new frame end waits until the result is taken.
// ----------------------------------------------------------------------------
module audio_frame_header_parser_core
  import afhp_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 33
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  afhp_cfg_if.sink     cfg_i,
  afhp_byte_if.sink    byte_i,
  afhp_hdr_if.source   hdr_o
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         in_go;
  logic         out_free;
  logic         out_valid_q;
  afhp_result_t out_q;
  afhp_result_t res;
  logic [7:0]   version_q;

  // Version register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VERSION_RESET;
    end else if (cfg_i.valid) begin
      version_q <= cfg_i.data;
    end
  end

  // Handshake: only a frame end needs a free result register
  assign out_free     = !out_valid_q || hdr_o.ready;
  assign in_go        = in_valid_q && (!in_last_q || out_free);
  assign byte_i.ready = !in_valid_q || in_go;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
      in_last_q <= byte_i.frame_end;
    end
  end

  // Parser
  afhp_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_go),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .version_i (version_q),
    .res_o     (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_go && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (hdr_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go && in_last_q) begin
      out_q <= res;
    end
  end

  assign hdr_o.valid           = out_valid_q;
  assign hdr_o.header_ok       = out_q.header_ok;
  assign hdr_o.frame_flags     = out_q.frame_flags;
  assign hdr_o.sequence_number = out_q.sequence_number;
  assign hdr_o.frame_stamp     = out_q.frame_stamp;
  assign hdr_o.payload_bytes   = out_q.payload_bytes;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for audio_frame_header_parser_core. Frames are built
// byte by byte (well-formed headers with random fields, corrupted and short
// frames, random noise) and sent over the byte channel with random gaps.
// Every accepted byte goes through a cycle-free model of the parser; each
// header that leaves the block is compared field by field with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  import afhp_pkg::*;

  // Counter width as in the default build
  localparam int unsigned TB_COUNT_BITS   = 33;
  localparam int unsigned RANDOM_BYTES    = 180;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned STALL_LIMIT     = 3000;

  // Model of the parser plus the queue of headers still to come out
  class header_book;
    logic [7:0]               version;
    logic [TB_COUNT_BITS-1:0] position;
    bit                       prefix_good;
    logic [7:0]               flags;
    logic [31:0]              seq_word;
    logic [63:0]              stamp;
    logic [31:0]              length;
    afhp_result_t             expected_headers[$];
    int unsigned              mismatches;

    function new();
      version     = VERSION_RESET;
      position    = '0;
      prefix_good = 1'b1;
      flags       = '0;
      seq_word    = '0;
      stamp       = '0;
      length      = '0;
      mismatches  = 0;
    endfunction

    // Advance the model by one accepted byte
    function void take_byte(logic [7:0] b, logic last);
      afhp_result_t hdr;
      logic [TB_COUNT_BITS-1:0] p;
      bit ok;
      p = position;
      if (p == MAGIC_AT     && b != MAGIC0)  prefix_good = 1'b0;
      if (p == MAGIC_AT + 1 && b != MAGIC1)  prefix_good = 1'b0;
      if (p == MAGIC_AT + 2 && b != MAGIC2)  prefix_good = 1'b0;
      if (p == MAGIC_AT + 3 && b != MAGIC3)  prefix_good = 1'b0;
      if (p == VERSION_AT   && b != version) prefix_good = 1'b0;
      if (p == FLAGS_AT) flags = b;
      if (p >= SEQ_AT && p < SEQ_AT + 4)     seq_word = {seq_word[23:0], b};
      if (p >= STAMP_AT && p < STAMP_AT + 8) stamp    = {stamp[55:0], b};
      if (p >= LEN_AT && p < LEN_AT + 4)     length   = {length[23:0], b};
      // saturating byte count
      if (p != '1) position = p + 1'b1;
      if (!last) return;
      ok = prefix_good && (position >= HEADER_BYTES) &&
           ({32'd0, length} + 64'(HEADER_BYTES) <= 64'(position));
      hdr = '0;
      if (ok) begin
        hdr.header_ok       = 1'b1;
        hdr.frame_flags     = flags;
        hdr.sequence_number = seq_word;
        hdr.frame_stamp     = stamp;
        hdr.payload_bytes   = length;
      end
      expected_headers = {expected_headers, hdr};
      position    = '0;
      prefix_good = 1'b1;
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: %0t %s expected %h got %h", $realtime, what, want, got);
    endfunction

    // Compare one header leaving the block with the oldest prediction
    function void match_header(afhp_result_t got);
      afhp_result_t want;
      if (expected_headers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: %0t header transfer with none pending", $realtime);
        return;
      end
      want = expected_headers.pop_front();
      if (got.header_ok !== want.header_ok)
        flag("header_ok", want.header_ok, got.header_ok);
      if (got.frame_flags !== want.frame_flags)
        flag("frame_flags", want.frame_flags, got.frame_flags);
      if (got.sequence_number !== want.sequence_number)
        flag("sequence_number", want.sequence_number, got.sequence_number);
      if (got.frame_stamp !== want.frame_stamp)
        flag("frame_stamp", want.frame_stamp, got.frame_stamp);
      if (got.payload_bytes !== want.payload_bytes)
        flag("payload_bytes", want.payload_bytes, got.payload_bytes);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic rx_hold = 1'b0;
  bit   tx_gaps = 1'b1;
  bit   rx_gaps = 1'b1;

  header_book hdr_book = new();
  logic [7:0] frame_buf[$];

  afhp_cfg_if  cfg_if();
  afhp_byte_if byte_if();
  afhp_hdr_if  hdr_if();

  audio_frame_header_parser_core #(
    .COUNT_BITS (TB_COUNT_BITS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .byte_i (byte_if),
    .hdr_o  (hdr_if)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Add one byte at the end of the frame buffer
  function automatic void append_byte(input logic [7:0] b);
    frame_buf = {frame_buf, b};
  endfunction

  // Append a 24-byte header to the frame buffer
  task automatic push_header(input logic [7:0] ver, input logic [7:0] flg,
                             input logic [31:0] seq_w, input logic [63:0] ts,
                             input logic [31:0] len);
    int i;
    append_byte(MAGIC0);
    append_byte(MAGIC1);
    append_byte(MAGIC2);
    append_byte(MAGIC3);
    append_byte(ver);
    append_byte(flg);
    append_byte(8'($urandom_range(0, 255)));
    append_byte(8'($urandom_range(0, 255)));
    for (i = 3; i >= 0; i--) append_byte(seq_w[8*i +: 8]);
    for (i = 7; i >= 0; i--) append_byte(ts[8*i +: 8]);
    for (i = 3; i >= 0; i--) append_byte(len[8*i +: 8]);
  endtask

  task automatic push_body(input int unsigned n);
    repeat (n) append_byte(8'($urandom_range(0, 255)));
  endtask

  // Send the frame buffer, frame_end on its last byte; valid stays up
  // after the last transfer so back-to-back frames need no gap
  task automatic send_frame();
    int unsigned i;
    int unsigned gap;
    bit last;
    for (i = 0; i < frame_buf.size(); i++) begin
      last = (i == frame_buf.size() - 1);
      byte_if.valid     <= 1'b1;
      byte_if.data_byte <= frame_buf[i];
      byte_if.frame_end <= last;
      do @(posedge clk_i); while (!byte_if.ready);
      hdr_book.take_byte(frame_buf[i], last);
      gap = tx_gaps ? pick_gap() : 0;
      if (gap != 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    frame_buf.delete();
  endtask

  // Mostly well-formed frames, some corrupted or cut short, some noise
  task automatic build_random_frame();
    int unsigned kind;
    int unsigned cut;
    int unsigned body;
    int unsigned pos;
    logic [31:0] plen;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      push_body($urandom_range(1, 40));
      return;
    end
    plen = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 12));
    push_header(hdr_book.version, 8'($urandom), $urandom, {$urandom, $urandom}, plen);
    if (kind < 24) begin
      // broken magic or version
      pos = $urandom_range(0, VERSION_AT);
      frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
    end else if (kind < 32) begin
      // frame ends inside the header
      cut = $urandom_range(1, HEADER_BYTES - 1);
      while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      return;
    end
    if (plen > 12) begin
      body = $urandom_range(0, 8);
    end else begin
      case ($urandom_range(0, 3))
        0, 1: body = plen;
        2:    body = plen + $urandom_range(1, 4);
        default: body = (plen > 0) ? plen - 1 : 0;
      endcase
    end
    push_body(body);
  endtask

  task automatic run_random(input int unsigned n_bytes);
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_random_frame();
      sent += frame_buf.size();
      send_frame();
    end
  endtask

  // Stop sending and wait until every header has come out
  task automatic drain();
    byte_if.valid <= 1'b0;
    while (hdr_book.expected_headers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_version(input logic [7:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    hdr_book.version = v;
  endtask

  // Long receiver hold-off, counted in its own process
  task automatic hold_receiver();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
  endtask

  // Header receiver: checks each transfer, stalls at random
  initial begin
    afhp_result_t got;
    int unsigned  rx_wait;
    rx_wait = 0;
    hdr_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hdr_if.valid && hdr_if.ready) begin
        got.header_ok       = hdr_if.header_ok;
        got.frame_flags     = hdr_if.frame_flags;
        got.sequence_number = hdr_if.sequence_number;
        got.frame_stamp     = hdr_if.frame_stamp;
        got.payload_bytes   = hdr_if.payload_bytes;
        hdr_book.match_header(got);
      end
      if (rx_hold) begin
        hdr_if.ready <= 1'b0;
      end else if (rx_wait != 0) begin
        hdr_if.ready <= 1'b0;
        rx_wait--;
      end else begin
        hdr_if.ready <= 1'b1;
        if (rx_gaps) rx_wait = pick_gap();
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((byte_if.valid && byte_if.ready) || (hdr_if.valid && hdr_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus
  initial begin
    int k;
    rst_ni            <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.data       <= '0;
    byte_if.valid     <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.frame_end <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames with the reset version
    // good, minimal length, field extremes
    push_header(VERSION_RESET, 8'h00, 32'h0, 64'h8000_0000_0000_0000, 32'd0);
    send_frame();
    // good, payload exactly present
    push_header(VERSION_RESET, 8'hFF, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 32'd3);
    append_byte(8'h00);
    append_byte(8'hFF);
    append_byte(8'h5A);
    send_frame();
    // payload one byte short
    push_header(VERSION_RESET, 8'h81, 32'h8000_0001, 64'h1, 32'd3);
    push_body(2);
    send_frame();
    // largest payload length, cannot be met
    push_header(VERSION_RESET, 8'hA5, 32'h1234_5678, '1, 32'hFFFF_FFFF);
    send_frame();
    // each magic byte and the version byte wrong in turn
    for (k = 0; k <= VERSION_AT; k++) begin
      push_header(VERSION_RESET, 8'h3C, $urandom, {$urandom, $urandom}, 32'd0);
      frame_buf[k] = frame_buf[k] ^ 8'h20;
      send_frame();
    end
    // frame of one byte, then a header cut one byte short
    append_byte(MAGIC0);
    send_frame();
    push_header(VERSION_RESET, 8'h11, $urandom, {$urandom, $urandom}, 32'd0);
    void'(frame_buf.pop_back());
    send_frame();
    drain();

    write_version(8'h00);
    run_random(RANDOM_BYTES);
    drain();

    // no idling on either side, receiver held off at the start
    write_version(8'hFF);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_receiver();
    run_random(RANDOM_BYTES);
    drain();

    write_version(8'($urandom_range(0, 255)));
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    hold_receiver();
    run_random(RANDOM_BYTES);
    drain();

    // Back to the reset version
    write_version(VERSION_RESET);
    run_random(RANDOM_BYTES);

    // Wind down
    byte_if.valid <= 1'b0;
    while (hdr_book.expected_headers.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (hdr_book.mismatches == 0 && hdr_book.expected_headers.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
hdl/afhp_pkg.sv
hdl/afhp_intf.sv
hdl/afhp_parser.sv
hdl/audio_frame_header_parser_core.sv
tb/tb_top.sv
